/* rtl/arr_pkg.sv */
// Package for the address range registry: payload structs, status and kind
// codes, sequencer states and default sizes. No dependencies.

package arr_pkg;

  // Default sizes, handed to the top level parameters
  localparam int unsigned ENTRIES_DEF  = 128;
  localparam int unsigned TAG_BITS_DEF = 16;

  // Fixed payload widths
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned SPAN_W   = 32;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned INDEX_W  = 7;
  localparam int unsigned COUNT_W  = 8;

  // Item kind
  localparam logic KIND_REGISTER = 1'b0;
  localparam logic KIND_LOOKUP   = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_DUP     = 3'd1,
    ST_INVALID = 3'd2,
    ST_FULL    = 3'd3,
    ST_HIT     = 3'd4,
    ST_MISS    = 3'd5
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [SPAN_W-1:0] span;
    logic [TAG_W-1:0]  owner_tag;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic               overflow_first;
    logic [INDEX_W-1:0] entry_index;
    logic [ADDR_W-1:0]  match_base;
    logic [SPAN_W-1:0]  match_span;
    logic [TAG_W-1:0]   match_tag;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

endpackage

/* rtl/address_range_registry_top.sv */
// Address range registry: range table in synchronous memory, scan sequencer
// and result register. Depends on arr_pkg.

// An accepted item scans the filled entries in order and the scan stops early
// on the first matching entry; a registration with a zero base, span or tag
// skips the scan. The scan is paced by the table's single read port, which the
// sequencer walks one entry per cycle. One item is in flight at a time; a new
// item is taken while the previous result still waits in the output register.
// The table needs no clearing after reset: only entries below the fill count
// are ever read.

module address_range_registry_top
  import arr_pkg::*;
#(
  parameter int unsigned ENTRIES  = ENTRIES_DEF,
  parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned TB_W  = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

  // Range table
  logic [ADDR_W-1:0] base_mem [ENTRIES];
  logic [SPAN_W-1:0] span_mem [ENTRIES];
  logic [TB_W-1:0]   tag_mem  [ENTRIES];

  state_t state, state_next;

  // Control
  logic [CNT_W-1:0] count, count_next;
  logic             ovf_seen, ovf_seen_next;
  logic [CNT_W-1:0] issue_idx;
  logic             pend_valid;
  logic             found;
  logic             bad_item;

  // Payload
  in_item_t          item;
  logic [TB_W-1:0]   item_tag;
  logic [IDX_W-1:0]  pend_idx;
  logic [ADDR_W-1:0] rd_base;
  logic [SPAN_W-1:0] rd_span;
  logic [TB_W-1:0]   rd_tag;
  logic [IDX_W-1:0]  hit_idx;
  logic [ADDR_W-1:0] hit_base;
  logic [SPAN_W-1:0] hit_span;
  logic [TB_W-1:0]   hit_tag;

  logic              in_xfer;
  logic              out_free;
  logic              rd_en;
  logic              match_now;
  logic              scan_done;
  logic              finish;
  logic              wr_en;
  logic [ADDR_W:0]   diff;
  logic              in_range;
  logic              in_bad;
  out_item_t         result;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign in_bad   = (in_data.kind == KIND_REGISTER) &&
                    ((in_data.owner_tag[TB_W-1:0] == '0) || (in_data.address == '0) ||
                     (in_data.span == '0));

  // Range test without wrap: borrow flags address below base
  assign diff      = {1'b0, item.address} - {1'b0, rd_base};
  assign in_range  = !diff[ADDR_W] && (diff[ADDR_W-1:SPAN_W] == '0) &&
                     (diff[SPAN_W-1:0] < rd_span);
  assign match_now = (state == S_SCAN) && pend_valid &&
                     ((item.kind == KIND_REGISTER) ? (rd_base == item.address) : in_range);
  assign rd_en     = (state == S_SCAN) && !match_now && (issue_idx < count);
  assign scan_done = (state == S_SCAN) && !pend_valid && (issue_idx >= count);
  assign finish    = (state == S_FINISH) && out_free;

  // Result and state updates for the finishing item
  always_comb begin
    result        = '0;
    count_next    = count;
    ovf_seen_next = ovf_seen;
    wr_en         = 1'b0;
    if (item.kind == KIND_LOOKUP) begin
      if (found) begin
        result.status      = ST_HIT;
        result.entry_index = INDEX_W'(32'(hit_idx));
        result.match_base  = hit_base;
        result.match_span  = hit_span;
        result.match_tag   = TAG_W'(hit_tag);
      end else begin
        result.status = ST_MISS;
      end
    end else if (bad_item) begin
      result.status = ST_INVALID;
    end else if (found) begin
      result.status = ST_DUP;
    end else if (count == FULL_COUNT) begin
      result.status         = ST_FULL;
      result.overflow_first = !ovf_seen;
      ovf_seen_next         = 1'b1;
    end else begin
      result.status      = ST_ADDED;
      result.entry_index = INDEX_W'(32'(count));
      count_next         = count + 1'b1;
      wr_en              = 1'b1;
    end
    result.entry_count = COUNT_W'(32'(count_next));
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = in_bad ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (match_now || scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      ovf_seen   <= 1'b0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      issue_idx  <= '0;
      found      <= 1'b0;
      bad_item   <= 1'b0;
    end else begin
      pend_valid <= rd_en;
      if (in_xfer) begin
        issue_idx <= '0;
        found     <= 1'b0;
        bad_item  <= in_bad;
      end else if (rd_en) begin
        issue_idx <= issue_idx + 1'b1;
      end
      if (match_now) begin
        found <= 1'b1;
      end
      if (finish) begin
        count     <= count_next;
        ovf_seen  <= ovf_seen_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item, match and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item     <= in_data;
      item_tag <= in_data.owner_tag[TB_W-1:0];
    end
    if (rd_en) begin
      pend_idx <= issue_idx[IDX_W-1:0];
    end
    if (match_now) begin
      hit_idx  <= pend_idx;
      hit_base <= rd_base;
      hit_span <= rd_span;
      hit_tag  <= rd_tag;
    end
    if (finish) begin
      out_data <= result;
    end
  end

  // Table: one write port on append, one registered read port for the scan
  always_ff @(posedge clk) begin
    if (finish && wr_en) begin
      base_mem[count[IDX_W-1:0]] <= item.address;
      span_mem[count[IDX_W-1:0]] <= item.span;
      tag_mem[count[IDX_W-1:0]]  <= item_tag;
    end
    if (rd_en) begin
      rd_base <= base_mem[issue_idx[IDX_W-1:0]];
      rd_span <= span_mem[issue_idx[IDX_W-1:0]];
      rd_tag  <= tag_mem[issue_idx[IDX_W-1:0]];
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("fill count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |-> (count == CNT_W'($past(count) + 1'b1)))
    else $error("fill count moved by other than one");

  a_read_filled: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (CNT_W'(pend_idx) < count))
    else $error("read of an unfilled entry");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(ovf_seen && !rst) |-> ovf_seen)
    else $error("overflow flag cleared outside reset");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.overflow_first) |-> (out_data.status == ST_FULL))
    else $error("overflow flag on a result other than full");

endmodule

/* bench/testbench.sv */
// Self-checking bench for address_range_registry_top: random and directed
// registrations and lookups, checked against a shadow copy of the range table.
// Depends on arr_pkg and the top level RTL.

module testbench;
  import arr_pkg::*;

  localparam int unsigned TABLE_SLOTS  = ENTRIES_DEF;
  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  // Shadow of the range table; predicts one result per accepted item
  class range_registry_shadow;
    logic [ADDR_W-1:0] base_tab [TABLE_SLOTS];
    logic [SPAN_W-1:0] span_tab [TABLE_SLOTS];
    logic [TAG_W-1:0]  tag_tab  [TABLE_SLOTS];
    int unsigned       filled;
    bit                overflow_seen;
    out_item_t         awaited_results [$];
    int unsigned       status_tally [6];
    int unsigned       results_checked;
    int unsigned       mismatches;

    function new();
      filled        = 0;
      overflow_seen = 1'b0;
    endfunction

    // Work out the result of one accepted transfer and queue it
    function void note_accepted(in_item_t item);
      out_item_t   want;
      int unsigned j;
      bit          found;
      want        = '0;
      want.status = ST_MISS;
      found       = 1'b0;
      if (item.kind == KIND_REGISTER) begin
        if (item.owner_tag == '0 || item.address == '0 || item.span == '0) begin
          want.status = ST_INVALID;
        end else begin
          for (j = 0; j < filled; j++) begin
            if (base_tab[j] == item.address) found = 1'b1;
          end
          if (found) begin
            want.status = ST_DUP;
          end else if (filled >= TABLE_SLOTS) begin
            want.status = ST_FULL;
            if (!overflow_seen) begin
              overflow_seen       = 1'b1;
              want.overflow_first = 1'b1;
            end
          end else begin
            base_tab[filled] = item.address;
            span_tab[filled] = item.span;
            tag_tab[filled]  = item.owner_tag;
            want.entry_index = INDEX_W'(filled);
            want.status      = ST_ADDED;
            filled++;
          end
        end
      end else begin
        // first filled slot whose range holds the address, no wrap at the top
        for (j = 0; j < filled && !found; j++) begin
          if (item.address >= base_tab[j] &&
              (item.address - base_tab[j]) < {32'd0, span_tab[j]}) begin
            found            = 1'b1;
            want.status      = ST_HIT;
            want.entry_index = INDEX_W'(j);
            want.match_base  = base_tab[j];
            want.match_span  = span_tab[j];
            want.match_tag   = tag_tab[j];
          end
        end
      end
      want.entry_count = COUNT_W'(filled);
      status_tally[int'(want.status)]++;
      awaited_results.push_back(want);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, seen);
        mismatches++;
      end
    endfunction

    // Compare one result transfer with the oldest prediction
    function void check_result(out_item_t seen);
      out_item_t want;
      results_checked++;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with nothing awaited, expected none, actual %h", $time, seen);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("status", want.status, seen.status);
      compare_field("overflow_first", want.overflow_first, seen.overflow_first);
      compare_field("entry_index", want.entry_index, seen.entry_index);
      compare_field("match_base", want.match_base, seen.match_base);
      compare_field("match_span", want.match_span, seen.match_span);
      compare_field("match_tag", want.match_tag, seen.match_tag);
      compare_field("entry_count", want.entry_count, seen.entry_count);
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  bit          calm      = 1'b0;
  int unsigned cycle_count = 0;

  range_registry_shadow shadow = new();

  address_range_registry_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) shadow.check_result(out_data);
  end

  // Result side: random stall before each transfer, none in calm stretches
  initial begin
    int unsigned stall;
    wait (!rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic in_item_t pack_item(logic kind, logic [ADDR_W-1:0] address,
                                         logic [SPAN_W-1:0] span, logic [TAG_W-1:0] tag);
    in_item_t item;
    item.kind      = kind;
    item.address   = address;
    item.span      = span;
    item.owner_tag = tag;
    return item;
  endfunction

  // Offer one item after a random gap; valid stays up across back-to-back items
  task automatic send_item(input in_item_t item);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    shadow.note_accepted(item);
  endtask

  // Mostly well-formed registrations and lookups aimed at stored ranges
  function automatic in_item_t draw_item();
    in_item_t          item;
    int unsigned       pick;
    int unsigned       j;
    logic [ADDR_W-1:0] b;
    logic [SPAN_W-1:0] s;
    item.kind      = KIND_LOOKUP;
    item.address   = {$urandom, $urandom};
    item.span      = $urandom;
    item.owner_tag = TAG_W'($urandom);
    pick = $urandom_range(0, 99);
    // nothing stored yet to aim at
    if (shadow.filled == 0 && pick >= 22 && pick < 85) pick = 0;
    j = (shadow.filled == 0) ? 0 : $urandom_range(0, shadow.filled - 1);
    if (pick < 22) begin
      item.kind      = KIND_REGISTER;
      item.owner_tag = TAG_W'($urandom_range(1, 16'hFFFF));
      case ($urandom_range(0, 9))
        0, 1: begin
          // starts inside a stored range, or just past its end
          if (shadow.filled != 0)
            item.address = shadow.base_tab[j] + 64'($urandom_range(1, shadow.span_tab[j]));
        end
        2: item.address = {32'hFFFF_FFFF, $urandom};
        3: item.address = 64'($urandom_range(1, 1000));
        default: ;
      endcase
      if (item.address == '0) item.address = 64'd1;
      case ($urandom_range(0, 9))
        0: item.span = 32'd1;
        1: item.span = 32'hFFFF_FFFF;
        2, 3, 4: item.span = $urandom;
        default: item.span = $urandom_range(1, 4096);
      endcase
      if (item.span == '0) item.span = 32'd1;
    end else if (pick < 28) begin
      // repeated base
      item.kind      = KIND_REGISTER;
      item.address   = shadow.base_tab[j];
      item.owner_tag = TAG_W'($urandom_range(1, 16'hFFFF));
      item.span      = $urandom_range(1, 32'hFFFF_FFFF);
    end else if (pick < 33) begin
      item.kind = KIND_REGISTER;
      case ($urandom_range(0, 2))
        0: item.owner_tag = '0;
        1: item.address   = '0;
        default: item.span = '0;
      endcase
    end else if (pick < 85) begin
      b = shadow.base_tab[j];
      s = shadow.span_tab[j];
      case ($urandom_range(0, 9))
        0, 1, 2: item.address = b;
        3, 4: item.address = b + 64'(s) - 64'd1;
        5: item.address = b + 64'(s);
        6: item.address = b - 64'd1;
        default: item.address = b + 64'($urandom_range(0, s - 1));
      endcase
    end
    return item;
  endfunction

  initial begin
    int unsigned n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, rejected registrations, edges of ranges
    send_item(pack_item(KIND_LOOKUP, 64'd0, 32'd0, 16'd0));
    send_item(pack_item(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(pack_item(KIND_REGISTER, 64'h1000, 32'h100, 16'h0));
    send_item(pack_item(KIND_REGISTER, 64'h0, 32'h100, 16'h1));
    send_item(pack_item(KIND_REGISTER, 64'h1000, 32'h0, 16'h1));
    send_item(pack_item(KIND_REGISTER, 64'd1, 32'd1, 16'd1));
    send_item(pack_item(KIND_REGISTER, 64'hFFFF_FFFF_FFFF_FFF0, 32'hFFFF_FFFF, 16'hFFFF));
    send_item(pack_item(KIND_REGISTER, 64'h8000_0000_0000_0000, 32'h8000_0000, 16'h8000));
    send_item(pack_item(KIND_REGISTER, 64'h1000, 32'h100, 16'h1234));
    send_item(pack_item(KIND_REGISTER, 64'h1080, 32'h1000, 16'h4321));
    send_item(pack_item(KIND_REGISTER, 64'h1000, 32'h55, 16'h7777));
    send_item(pack_item(KIND_LOOKUP, 64'd1, 32'd0, 16'd0));
    send_item(pack_item(KIND_LOOKUP, 64'd2, 32'd0, 16'd0));
    send_item(pack_item(KIND_LOOKUP, 64'd0, 32'd0, 16'd0));
    send_item(pack_item(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 16'd0));
    send_item(pack_item(KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFEF, 32'd0, 16'd0));
    send_item(pack_item(KIND_LOOKUP, 64'h10FF, 32'd0, 16'd0));
    send_item(pack_item(KIND_LOOKUP, 64'h1100, 32'd0, 16'd0));
    send_item(pack_item(KIND_LOOKUP, 64'h8000_0000_7FFF_FFFF, 32'd0, 16'd0));
    send_item(pack_item(KIND_LOOKUP, 64'h8000_0000_8000_0000, 32'd0, 16'd0));
    send_item(pack_item(KIND_LOOKUP, 64'h1000, 32'hFFFF_FFFF, 16'hFFFF));

    // Random: table fills part way through, then drops when full
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      send_item(draw_item());
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (shadow.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("registrations: %0d added, %0d duplicate, %0d invalid, %0d dropped on a full table",
             shadow.status_tally[ST_ADDED], shadow.status_tally[ST_DUP],
             shadow.status_tally[ST_INVALID], shadow.status_tally[ST_FULL]);
    $display("lookups: %0d hits, %0d misses; %0d results checked, %0d mismatches",
             shadow.status_tally[ST_HIT], shadow.status_tally[ST_MISS],
             shadow.results_checked, shadow.mismatches);
    if (shadow.mismatches == 0 && shadow.awaited_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
